### design/assert_macros.svh
// Assertion helper macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### design/eds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_pkg: shared types and constants
// Payload structs, request kinds, controller states and the command bundle.
// ----------------------------------------------------------------------------
package eds_pkg;

    localparam int MaxLenDefault = 64;
    localparam int DistW         = 7;
    localparam int PctW          = 7;

    localparam logic [1:0] KIND_SOURCE  = 2'd0;
    localparam logic [1:0] KIND_TARGET  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] character;
    } in_item_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [PctW-1:0]  match_percent;
        logic             truncated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // accept a request into the datapath
        logic init_row;  // write row_mem[j] = j, advance j
        logic row_start; // begin row i
        logic cell_step; // evaluate one table entry
        logic div_start;
        logic div_step;
        logic finish;    // result accepted; clear lengths and truncation flag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_compute;
        logic init_last;
        logic rows_done;
        logic cell_last;
        logic div_done;
    } stat_t;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        if (en && c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

endpackage

### design/eds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_ctrl: sequencing state machine
// Walks init, row and cell phases, then the percentage divide and output.
// ----------------------------------------------------------------------------
module eds_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  eds_pkg::stat_t stat,
    output eds_pkg::cmd_t  cmd
);

    eds_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= eds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            eds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.is_compute)
                        state_next = eds_pkg::ST_INIT;
                end
            end
            eds_pkg::ST_INIT:
            begin
                cmd.init_row = 1'b1;
                if (stat.init_last)
                    state_next = eds_pkg::ST_ROW;
            end
            eds_pkg::ST_ROW:
            begin
                if (stat.rows_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = eds_pkg::ST_DIV;
                end
                else
                begin
                    cmd.row_start = 1'b1;
                    state_next    = eds_pkg::ST_CELL;
                end
            end
            eds_pkg::ST_CELL:
            begin
                cmd.cell_step = 1'b1;
                if (stat.cell_last)
                    state_next = eds_pkg::ST_ROW;
            end
            eds_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = eds_pkg::ST_OUT;
            end
            eds_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = eds_pkg::ST_IDLE;
                end
            end
            default: state_next = eds_pkg::ST_IDLE;
        endcase
    end

endmodule

### design/eds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_datapath: string stores, cost row and percentage divider
// One table cell per cycle, a setup step per row; restoring percentage divider.
// ----------------------------------------------------------------------------
module eds_datapath #(
    parameter int MAX_LEN = eds_pkg::MaxLenDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              case_fold,
    input  eds_pkg::in_item_t in_item,
    input  eds_pkg::cmd_t     cmd,
    output eds_pkg::stat_t    stat,
    output eds_pkg::out_item_t out_item
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int CW  = LW;              // cost values up to MAX_LEN
    localparam int NW  = LW + 8;          // 200*same + L
    localparam int DVW = LW + 1;          // 2*L

    logic [7:0] src_mem [MAX_LEN];
    logic [7:0] tgt_mem [MAX_LEN];
    logic [CW-1:0] row_mem [MAX_LEN+1];

    logic [LW-1:0] src_len_reg, tgt_len_reg;
    logic          ovf_reg;
    logic [LW-1:0] i_reg, j_reg;
    logic [CW-1:0] diag_reg, left_reg, up_reg;
    logic [7:0]    a_reg, b_reg;
    logic [NW-1:0] rem_reg, quo_reg;
    logic [DVW-1:0] den_reg;
    logic [$clog2(NW+1)-1:0] cnt_reg;
    logic [CW-1:0] dist_reg;

    logic src_full, tgt_full;
    assign src_full = (src_len_reg == LW'(MAX_LEN));
    assign tgt_full = (tgt_len_reg == LW'(MAX_LEN));

    // operands of the current entry were registered by the step before it
    logic [CW-1:0] cell_val, m1, m2;
    assign m1 = (diag_reg < up_reg) ? diag_reg : up_reg;
    assign m2 = (m1 < left_reg) ? m1 : left_reg;
    assign cell_val = (eds_pkg::fold(a_reg, case_fold) == eds_pkg::fold(b_reg, case_fold))
                    ? diag_reg : m2 + CW'(1);

    logic [LW-1:0] longer;
    assign longer = (src_len_reg > tgt_len_reg) ? src_len_reg : tgt_len_reg;

    // an empty string leaves the distance equal to the other length
    logic [CW-1:0] dist_val;
    assign dist_val = (src_len_reg == '0) ? CW'(tgt_len_reg)
                    : (tgt_len_reg == '0) ? CW'(src_len_reg) : left_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_item.kind == eds_pkg::KIND_SOURCE && !src_full)
            src_mem[src_len_reg[AW-1:0]] <= in_item.character;
        if (cmd.load && in_item.kind == eds_pkg::KIND_TARGET && !tgt_full)
            tgt_mem[tgt_len_reg[AW-1:0]] <= in_item.character;
        if (cmd.init_row)
            row_mem[j_reg] <= CW'(j_reg);
        if (cmd.row_start)
        begin
            diag_reg <= CW'(i_reg);
            left_reg <= CW'(i_reg + LW'(1));
            a_reg    <= src_mem[i_reg[AW-1:0]];
            up_reg   <= row_mem[1];
            b_reg    <= tgt_mem[0];
        end
        if (cmd.cell_step)
        begin
            row_mem[j_reg] <= cell_val;
            diag_reg       <= up_reg;
            left_reg       <= cell_val;
            if (!stat.cell_last)
            begin
                up_reg <= row_mem[j_reg + LW'(1)];
                b_reg  <= tgt_mem[j_reg[AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_len_reg <= '0;
            tgt_len_reg <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                j_reg <= '0;
                i_reg <= '0;
                if (in_item.kind == eds_pkg::KIND_SOURCE)
                begin
                    if (src_full) ovf_reg <= 1'b1;
                    else src_len_reg <= src_len_reg + LW'(1);
                end
                else if (in_item.kind == eds_pkg::KIND_TARGET)
                begin
                    if (tgt_full) ovf_reg <= 1'b1;
                    else tgt_len_reg <= tgt_len_reg + LW'(1);
                end
            end
            if (cmd.init_row)
                j_reg <= j_reg + LW'(1);
            if (cmd.row_start)
                j_reg <= LW'(1);
            if (cmd.cell_step)
            begin
                j_reg <= j_reg + LW'(1);
                if (j_reg >= tgt_len_reg)
                    i_reg <= i_reg + LW'(1);
            end
            if (cmd.div_start)
                cnt_reg <= '0;
            if (cmd.div_step)
                cnt_reg <= cnt_reg + ($bits(cnt_reg))'(1);
            if (cmd.finish)
            begin
                src_len_reg <= '0;
                tgt_len_reg <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [NW:0] trial;
    assign trial = {rem_reg, quo_reg[NW-1]} - (NW+1)'(den_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dist_reg <= dist_val;
            rem_reg  <= '0;
            quo_reg  <= NW'(200) * NW'((longer >= LW'(dist_val))
                        ? longer - LW'(dist_val) : LW'(0)) + NW'(longer);
            den_reg  <= {longer, 1'b0};
        end
        if (cmd.div_step && !stat.div_done)
        begin
            if (!trial[NW])
                rem_reg <= trial[NW-1:0];
            else
                rem_reg <= {rem_reg[NW-2:0], quo_reg[NW-1]};
            quo_reg <= {quo_reg[NW-2:0], !trial[NW]};
        end
    end

    logic [NW-1:0] pct;
    assign pct = (src_len_reg == '0 || tgt_len_reg == '0) ? '0
               : (quo_reg > NW'(100)) ? NW'(100) : quo_reg;

    always_comb
    begin
        stat.is_compute = (in_item.kind == eds_pkg::KIND_COMPUTE);
        stat.init_last  = (j_reg >= tgt_len_reg);
        stat.rows_done  = (i_reg >= src_len_reg);
        stat.cell_last  = (j_reg >= tgt_len_reg);
        stat.div_done   = (cnt_reg == ($bits(cnt_reg))'(NW));
        out_item.distance      = eds_pkg::DistW'(dist_reg);
        out_item.match_percent = pct[eds_pkg::PctW-1:0];
        out_item.truncated     = ovf_reg;
    end

endmodule

### design/edit_distance_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_similarity: Levenshtein distance with similarity percentage
// Load requests are accepted while idle. A compute request raises out_valid
// once it has walked the table, one table cell per cycle with a setup step
// per row, and then run the bit-serial divide. One request at a time;
// input reopens after the result.
// Reset clears lengths, the truncation flag and sets case folding on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module edit_distance_similarity #(
    parameter int MAX_LEN = eds_pkg::MaxLenDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  eds_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output eds_pkg::out_item_t out_data
);

    logic          fold_reg;
    eds_pkg::cmd_t  cmd;
    eds_pkg::stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_reg <= 1'b1;
        else if (cfg_we)
            fold_reg <= cfg_data;
    end

    eds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    eds_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk(clk), .rst_n(rst_n), .case_fold(fold_reg), .in_item(in_data),
        .cmd(cmd), .stat(stat), .out_item(out_data)
    );

    `ASSERT_IMPLIES(a_no_both, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `ASSERT_NEXT(a_out_clears, clk, rst_n, out_valid && out_ready, in_ready)
    `ASSERT_IMPLIES(a_pct_range, clk, rst_n, out_valid, out_data.match_percent <= 7'd100)

endmodule
